[rtl/queued_setpoint_exponential_ramp_core_assert.svh]
// Assertion macros shared by the ramp core RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef QUEUED_SETPOINT_EXPONENTIAL_RAMP_CORE_ASSERT_SVH
`define QUEUED_SETPOINT_EXPONENTIAL_RAMP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define QSER_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qser: same-cycle check failed");
// Next-cycle implication
`define QSER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qser: next-cycle check failed");
`else
`define QSER_ASSERT_IMPL(lbl, ante, cons)
`define QSER_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/qser_pkg.sv]
package qser_pkg;

  // Fixed field widths
  localparam int CMD_W    = 16;
  localparam int THRESH_W = 16;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // Register reset values (about 0.8 in Q.8)
  localparam int GAIN_RESET   = 205;
  localparam int THRESH_RESET = 205;

  // Register index codes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_GAIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_THRESHOLD = 2'd1;

  // Action codes of an input word
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Flags of one ramp step
  typedef struct packed {
    logic up;
    logic reached;
  } ramp_flags_t;

endpackage

[rtl/qser_ram.sv]
module qser_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/qser_ramp.sv]
module qser_ramp #(
  parameter int FRACTION_BITS = qser_pkg::FRACTION_BITS_DEF,
  localparam int SPEED_W = qser_pkg::CMD_W + FRACTION_BITS,
  localparam int GAIN_W  = FRACTION_BITS + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic [GAIN_W-1:0]                 gain,
  input  logic [qser_pkg::THRESH_W-1:0]     thresh,
  input  logic signed [qser_pkg::CMD_W-1:0] target_cmd,
  output logic signed [SPEED_W-1:0]         report,
  output qser_pkg::ramp_flags_t             flags
);

  localparam int DIFF_W = SPEED_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int SUM_W  = SPEED_W + 3;

  logic signed [SPEED_W-1:0]   cur_r;
  logic signed [SPEED_W-1:0]   cur_nxt;
  logic signed [SPEED_W-1:0]   target;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [GAIN_W:0]      gain_s;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    prod_sh;
  logic signed [SUM_W-1:0]     sum;
  logic [SUM_W-SPEED_W:0]      sum_hi;
  logic signed [SPEED_W-1:0]   sat;
  logic signed [DIFF_W-1:0]    dev;
  logic [DIFF_W-1:0]           dist_abs;
  logic                        reached;

  // Scale the command to fixed point and take the remaining difference
  assign target = {target_cmd, {FRACTION_BITS{1'b0}}};
  assign diff   = DIFF_W'(target) - DIFF_W'(cur_r);
  assign gain_s = signed'({1'b0, gain});

  // Apply the gain and floor-shift back to speed scale
  assign prod    = PROD_W'(diff) * PROD_W'(gain_s);
  assign prod_sh = prod >>> FRACTION_BITS;
  assign sum     = SUM_W'(cur_r) + SUM_W'(prod_sh);

  // Saturate to the speed range
  assign sum_hi = sum[SUM_W-1:SPEED_W-1];
  always_comb begin
    if (sum_hi == '0 || sum_hi == '1) begin
      sat = sum[SPEED_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SPEED_W-1){1'b1}}};
    end
  end

  // Compare the distance left with the settle threshold
  assign dev      = DIFF_W'(sat) - DIFF_W'(target);
  assign dist_abs = dev[DIFF_W-1] ? DIFF_W'(-dev) : DIFF_W'(dev);
  assign reached  = dist_abs < DIFF_W'(thresh);

  assign report        = reached ? target : sat;
  assign flags.up      = target > cur_r;
  assign flags.reached = reached;

  // Advance the current speed on each live tick (never snapped)
  assign cur_nxt = step_en ? sat : cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

endmodule

[rtl/queued_setpoint_exponential_ramp_core.sv]
// Queued setpoint ramp core.
// Input channel (in_valid / in_stall): each word is either a push of a signed
// 16-bit speed command (in_action = 0) or one ramp tick (in_action = 1).
// A push goes into the command queue and gives no result; on a full queue it
// is dropped and the sticky overflow flag sets. A tick with a queued command
// moves the speed toward the head command and returns one result word on the
// output channel (out_valid / out_stall); a tick on an empty queue gives none.
// Configuration: cfg_we with cfg_index 0 writes ramp_gain, 1 writes
// settle_threshold; other indexes are ignored. Write only while idle.
// Result path: a tick's result is registered on out_* as the tick leaves the
// work stage. Throughput: one input word per cycle while in_stall is low; the
// queue RAM and the speed register are read, modified and written per word
// (one multiply, add and compare per tick), and the head read is forwarded when
// the entry is written in the cycle before.
// Reset (rst_n low, synchronous): queue empty, speed zero, flag clear,
// registers back to 205. No clearing pass: queue entries are read only
// after being written.
// Output stall: the result register holds; pushes keep flowing, and the
// next tick with a queued command waits, raising in_stall.
module queued_setpoint_exponential_ramp_core #(
  parameter int QUEUE_DEPTH   = qser_pkg::QUEUE_DEPTH_DEF,
  parameter int FRACTION_BITS = qser_pkg::FRACTION_BITS_DEF,
  localparam int SPEED_W = qser_pkg::CMD_W + FRACTION_BITS,
  localparam int GAIN_W  = FRACTION_BITS + 1,
  localparam int CFG_W   = (GAIN_W > qser_pkg::THRESH_W) ? GAIN_W : qser_pkg::THRESH_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic signed [qser_pkg::CMD_W-1:0]  in_command_speed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SPEED_W-1:0]          out_speed_now,
  output logic                               out_speeding_up,
  output logic                               out_target_reached,
  output logic                               out_overflow_seen,
  input  logic                               cfg_we,
  input  logic [qser_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data
);

  `include "queued_setpoint_exponential_ramp_core_assert.svh"

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  logic [GAIN_W-1:0]             gain_r;
  logic [qser_pkg::THRESH_W-1:0] thresh_r;

  // Work stage
  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  logic                              s1_action_r;
  logic signed [qser_pkg::CMD_W-1:0] s1_cmd_r;

  // Queue control
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] tail_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             byp_r;
  logic [qser_pkg::CMD_W-1:0] byp_data_r;
  logic [qser_pkg::CMD_W-1:0] ram_rdata;
  logic signed [qser_pkg::CMD_W-1:0] head_cmd;

  // Output register
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [SPEED_W-1:0] out_speed_r;
  qser_pkg::ramp_flags_t     out_flags_r;
  logic                      out_ovf_r;

  // Handshake and step control
  logic fifo_full;
  logic fifo_empty;
  logic is_push;
  logic is_tick;
  logic tick_live;
  logic out_free;
  logic s1_go;
  logic in_fire;
  logic wr_en;
  logic pop;
  logic out_load;

  logic signed [SPEED_W-1:0] ramp_report;
  qser_pkg::ramp_flags_t     ramp_flags;

  // Decode the work stage word
  assign fifo_full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign fifo_empty = cnt_r == '0;
  assign is_push    = s1_valid_r && (s1_action_r == qser_pkg::ACT_PUSH);
  assign is_tick    = s1_valid_r && (s1_action_r == qser_pkg::ACT_TICK);
  assign tick_live  = is_tick && !fifo_empty;
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_go      = s1_valid_r && (!tick_live || out_free);
  assign in_stall   = s1_valid_r && !s1_go;
  assign in_fire    = in_valid && !in_stall;

  assign wr_en    = s1_go && is_push && !fifo_full;
  assign out_load = s1_go && tick_live;
  assign pop      = out_load && ramp_flags.reached;

  // Advance the queue pointers, count and overflow flag
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    if (pop) begin
      head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (wr_en) begin
      tail_nxt = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (s1_go && is_push && fifo_full) begin
      ovf_nxt = 1'b1;
    end
  end

  // Hold the work stage while its tick waits on the output
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  // Command queue storage; read the head for the next word each cycle
  qser_ram #(
    .WIDTH (qser_pkg::CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail_r),
    .wdata (s1_cmd_r),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  // Forward a head entry written in the same cycle as its read
  assign head_cmd = byp_r ? signed'(byp_data_r) : signed'(ram_rdata);

  qser_ramp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ramp (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (out_load),
    .gain       (gain_r),
    .thresh     (thresh_r),
    .target_cmd (head_cmd),
    .report     (ramp_report),
    .flags      (ramp_flags)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      byp_r       <= wr_en && (tail_r == head_nxt);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_W'(qser_pkg::GAIN_RESET);
      thresh_r <= qser_pkg::THRESH_W'(qser_pkg::THRESH_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        qser_pkg::CFG_RAMP_GAIN:        gain_r   <= cfg_data[GAIN_W-1:0];
        qser_pkg::CFG_SETTLE_THRESHOLD: thresh_r <= cfg_data[qser_pkg::THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_cmd_r    <= in_command_speed;
    end
    byp_data_r <= s1_cmd_r;
    if (out_load) begin
      out_speed_r <= ramp_report;
      out_flags_r <= ramp_flags;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_speed_now      = out_speed_r;
  assign out_speeding_up    = out_flags_r.up;
  assign out_target_reached = out_flags_r.reached;
  assign out_overflow_seen  = out_ovf_r;

  `QSER_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `QSER_ASSERT_NEXT(a_ovf_sticky, ovf_r, ovf_r)
  `QSER_ASSERT_NEXT(a_pop_count, pop, cnt_r == $past(cnt_r) - 1'b1)
  `QSER_ASSERT_NEXT(a_push_count, wr_en, cnt_r == $past(cnt_r) + 1'b1)

endmodule
